// ----- rtl/clrb_pkg.sv -----
package clrb_pkg;

  // Input operation codes
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  // Result kinds
  localparam logic [1:0] RK_ECHO = 2'd0;
  localparam logic [1:0] RK_POP  = 2'd1;
  localparam logic [1:0] RK_PEEK = 2'd2;

  // Control characters
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [11:0] LINE_COUNT_MAX = 12'hFFF;

  // Configuration registers, selected by address bit 2
  localparam int          CFG_AW       = 3;
  localparam logic        REG_ECHO_DIS = 1'b0;
  localparam logic        REG_MAX_LINE = 1'b1;
  localparam logic [12:0] MAX_LINE_RST = 13'd256;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef enum logic [1:0] {
    ACT_RECEIVE,
    ACT_POP,
    ACT_PEEK
  } clrb_act_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ECHO,
    BK_POP,
    BK_PEEK
  } clrb_bk_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       end_of_packet;
  } clrb_cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic        buffer_empty;
    logic        line_end;
    logic        kept;
    logic [11:0] line_count;
    logic        found;
    logic [7:0]  position;
    logic        last;
  } clrb_rsp_t;

  // Classified command as it travels through the queue
  typedef struct packed {
    clrb_act_t   act;
    logic [7:0]  data;
    logic        edit;
    logic        is_bs;
    logic        is_lf;
    logic        is_cr;
    logic        is_term;
    logic [12:0] limit;
  } clrb_entry_t;

  function automatic logic is_line_term(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_ESC);
  endfunction

endpackage

// ----- rtl/clrb_ram.sv -----
module clrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/clrb_front.sv -----
module clrb_front import clrb_pkg::*; (
  input  logic        start,
  input  clrb_cmd_t   cmd,
  input  logic        echo_disable,
  input  logic [12:0] max_line_length,
  input  logic        q_full,
  output logic        busy,
  output logic        push,
  output clrb_entry_t entry
);

  logic accept;
  logic known;

  assign busy   = q_full;
  assign accept = start && !q_full;

  // Classify the byte and capture the configuration in force at acceptance
  always_comb begin
    entry         = '0;
    known         = 1'b1;
    entry.data    = cmd.data_byte;
    entry.edit    = !echo_disable;
    entry.is_bs   = (cmd.data_byte == CH_BS);
    entry.is_lf   = (cmd.data_byte == CH_LF);
    entry.is_cr   = (cmd.data_byte == CH_CR);
    entry.is_term = is_line_term(cmd.data_byte);
    entry.limit   = (max_line_length == 13'd0) ? 13'd0 : max_line_length - 13'd1;
    case (cmd.operation)
      OP_RECEIVE: entry.act = ACT_RECEIVE;
      OP_POP:     entry.act = ACT_POP;
      OP_PEEK:    entry.act = ACT_PEEK;
      default: begin
        // unknown operation: drop it
        entry.act = ACT_RECEIVE;
        known     = 1'b0;
      end
    endcase
  end

  assign push = accept && known;

endmodule

// ----- rtl/clrb_cmdq.sv -----
module clrb_cmdq import clrb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  clrb_entry_t entry,
  output logic        full,
  input  logic        take,
  output clrb_entry_t head,
  output logic        head_valid
);

  clrb_entry_t slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               do_take;

  assign full       = (count == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_take    = take && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_take) begin
        count <= count + 1'b1;
      end else if (!push && do_take) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

// ----- rtl/clrb_back.sv -----
module clrb_back import clrb_pkg::*; #(
  parameter int BUFFER_DEPTH = 256,
  localparam int PW = $clog2(BUFFER_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  clrb_entry_t   head,
  input  logic          head_valid,
  output logic          head_take,
  output logic          ram_we,
  output logic [PW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          ram_re,
  output logic [PW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output clrb_rsp_t     rsp,
  output logic          rsp_valid
);

  localparam logic [PW-1:0] LAST_IDX = PW'(BUFFER_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  clrb_bk_state_t state, state_next;

  logic [PW-1:0] wp, wp_next;
  logic [PW-1:0] rp, rp_next;
  logic          prev_cr, prev_cr_next;
  logic [11:0]   line_cnt, line_cnt_next;
  logic [7:0]    eb1, eb1_next;
  logic [7:0]    eb2, eb2_next;
  logic [1:0]    ecnt, ecnt_next;
  logic [1:0]    eidx, eidx_next;
  logic [12:0]   pop_limit, pop_limit_next;
  logic [7:0]    key, key_next;
  logic [PW-1:0] avail, avail_next;
  logic [PW-1:0] ic, ic_next;
  logic [PW-1:0] peek_ptr, peek_ptr_next;
  logic          cmp_v, cmp_v_next;
  logic [PW-1:0] cmp_i, cmp_i_next;
  clrb_rsp_t     rsp_next;
  logic          rsp_valid_next;

  logic [PW-1:0] wp_inc, wp_dec;
  logic          buf_empty, buf_full;
  logic [PW:0]   used_w;
  logic [PW-1:0] used;
  logic          peek_hit, peek_done;
  logic [PW+7:0] pos_ext;

  // receive plan
  logic       rx_store;
  logic       rx_back;
  logic       rx_prev_cr;
  logic [1:0] rx_ecnt;
  logic [7:0] rx_eb0, rx_eb1, rx_eb2;

  assign wp_inc    = ptr_inc(wp);
  assign wp_dec    = (wp == '0) ? LAST_IDX : wp - 1'b1;
  assign buf_empty = (wp == rp);
  assign buf_full  = (wp_inc == rp);
  assign used_w    = (wp >= rp) ? ({1'b0, wp} - {1'b0, rp})
                                : ({1'b0, wp} + (PW+1)'(BUFFER_DEPTH) - {1'b0, rp});
  assign used      = used_w[PW-1:0];
  assign peek_hit  = cmp_v && (ram_rdata == key);
  assign peek_done = cmp_v && (peek_hit || (cmp_i == avail - 1'b1));
  assign pos_ext   = {8'b0, cmp_i};

  // Editing decisions for a received byte
  always_comb begin
    rx_store   = 1'b0;
    rx_back    = 1'b0;
    rx_prev_cr = prev_cr;
    rx_ecnt    = 2'd0;
    rx_eb0     = head.data;
    rx_eb1     = CH_SP;
    rx_eb2     = CH_BS;
    if (head.edit) begin
      if (head.is_bs) begin
        if (!buf_empty) begin
          rx_back = 1'b1;
          rx_ecnt = 2'd3;
          rx_eb0  = CH_BS;
        end
      end else if (head.is_lf && prev_cr) begin
        rx_prev_cr = 1'b0;
      end else begin
        if (head.is_term) begin
          rx_eb0  = CH_LF;
          rx_ecnt = 2'd1;
          if (head.is_cr) begin
            rx_prev_cr = 1'b1;
          end
        end
        if (!buf_full) begin
          rx_store = 1'b1;
          if (head.is_term) begin
            rx_eb1  = CH_CR;
            rx_ecnt = 2'd2;
          end else begin
            rx_ecnt = 2'd1;
          end
        end
      end
    end else begin
      rx_store = !buf_full;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          case (head.act)
            ACT_RECEIVE: if (rx_ecnt >= 2'd2) state_next = BK_ECHO;
            ACT_POP:     if (!buf_empty) state_next = BK_POP;
            ACT_PEEK:    if (used != '0) state_next = BK_PEEK;
            default:     state_next = BK_IDLE;
          endcase
        end
      end
      BK_ECHO: if (eidx == ecnt - 2'd1) state_next = BK_IDLE;
      BK_POP:  state_next = BK_IDLE;
      BK_PEEK: if (peek_done) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    wp_next        = wp;
    rp_next        = rp;
    prev_cr_next   = prev_cr;
    line_cnt_next  = line_cnt;
    eb1_next       = eb1;
    eb2_next       = eb2;
    ecnt_next      = ecnt;
    eidx_next      = eidx;
    pop_limit_next = pop_limit;
    key_next       = key;
    avail_next     = avail;
    ic_next        = ic;
    peek_ptr_next  = peek_ptr;
    cmp_v_next     = cmp_v;
    cmp_i_next     = cmp_i;
    rsp_next       = '0;
    rsp_valid_next = 1'b0;
    head_take      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = wp;
    ram_wdata      = head.data;
    ram_re         = 1'b0;
    ram_raddr      = rp;
    case (state)
      BK_IDLE: begin
        if (head_valid) begin
          head_take = 1'b1;
          case (head.act)
            ACT_RECEIVE: begin
              ram_we       = rx_store;
              prev_cr_next = rx_prev_cr;
              eb1_next     = rx_eb1;
              eb2_next     = rx_eb2;
              ecnt_next    = rx_ecnt;
              eidx_next    = 2'd1;
              if (rx_store) begin
                wp_next = wp_inc;
              end else if (rx_back) begin
                wp_next = wp_dec;
              end
              if (rx_ecnt != 2'd0) begin
                rsp_valid_next       = 1'b1;
                rsp_next.result_kind = RK_ECHO;
                rsp_next.out_byte    = rx_eb0;
                rsp_next.last        = (rx_ecnt == 2'd1);
              end
            end
            ACT_POP: begin
              if (buf_empty) begin
                rsp_valid_next        = 1'b1;
                rsp_next.result_kind  = RK_POP;
                rsp_next.buffer_empty = 1'b1;
                rsp_next.line_count   = line_cnt;
                rsp_next.last         = 1'b1;
              end else begin
                ram_re         = 1'b1;
                rp_next        = ptr_inc(rp);
                pop_limit_next = head.limit;
              end
            end
            ACT_PEEK: begin
              if (used == '0) begin
                rsp_valid_next       = 1'b1;
                rsp_next.result_kind = RK_PEEK;
                rsp_next.last        = 1'b1;
              end else begin
                key_next      = head.data;
                avail_next    = used;
                ic_next       = '0;
                peek_ptr_next = rp;
                cmp_v_next    = 1'b0;
              end
            end
            default: head_take = 1'b1;
          endcase
        end
      end
      BK_ECHO: begin
        rsp_valid_next       = 1'b1;
        rsp_next.result_kind = RK_ECHO;
        rsp_next.out_byte    = (eidx == 2'd2) ? eb2 : eb1;
        rsp_next.last        = (eidx == ecnt - 2'd1);
        eidx_next            = eidx + 2'd1;
      end
      BK_POP: begin
        rsp_valid_next       = 1'b1;
        rsp_next.result_kind = RK_POP;
        rsp_next.out_byte    = ram_rdata;
        rsp_next.last        = 1'b1;
        rsp_next.line_count  = line_cnt;
        if (is_line_term(ram_rdata)) begin
          rsp_next.line_end = 1'b1;
          line_cnt_next     = '0;
        end else if (({1'b0, line_cnt} < pop_limit) && (line_cnt != LINE_COUNT_MAX)) begin
          rsp_next.kept       = 1'b1;
          rsp_next.line_count = line_cnt + 12'd1;
          line_cnt_next       = line_cnt + 12'd1;
        end
      end
      BK_PEEK: begin
        // issue one read per cycle, compare the byte read the cycle before
        if (ic < avail) begin
          ram_re        = 1'b1;
          ram_raddr     = peek_ptr;
          peek_ptr_next = ptr_inc(peek_ptr);
          ic_next       = ic + 1'b1;
          cmp_v_next    = 1'b1;
          cmp_i_next    = ic;
        end else begin
          cmp_v_next = 1'b0;
        end
        if (peek_done) begin
          rsp_valid_next       = 1'b1;
          rsp_next.result_kind = RK_PEEK;
          rsp_next.found       = peek_hit;
          rsp_next.position    = peek_hit ? pos_ext[7:0] : 8'd0;
          rsp_next.last        = 1'b1;
        end
      end
      default: head_take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      wp        <= '0;
      rp        <= '0;
      prev_cr   <= 1'b0;
      line_cnt  <= '0;
      rsp_valid <= 1'b0;
      cmp_v     <= 1'b0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      rp        <= rp_next;
      prev_cr   <= prev_cr_next;
      line_cnt  <= line_cnt_next;
      rsp_valid <= rsp_valid_next;
      cmp_v     <= cmp_v_next;
    end
  end

  always_ff @(posedge clk) begin
    eb1       <= eb1_next;
    eb2       <= eb2_next;
    ecnt      <= ecnt_next;
    eidx      <= eidx_next;
    pop_limit <= pop_limit_next;
    key       <= key_next;
    avail     <= avail_next;
    ic        <= ic_next;
    peek_ptr  <= peek_ptr_next;
    cmp_i     <= cmp_i_next;
    rsp       <= rsp_next;
  end

endmodule

// ----- rtl/console_line_rx_buffer_top.sv -----
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+---------------------------
// command   | start & !busy accepts              | cmd  (clrb_cmd_t)
// result    | rsp_valid, one cycle per result    | rsp  (clrb_rsp_t)
// config    | APB write: psel&penable&pwrite     | paddr[2] selects, pwdata
//
// A transaction enters a two-deep command queue; busy is high only while the
// queue is full. The back end drains the queue one transaction at a time:
// receive gives up to 3 echo results, pop makes one byte-store read unless the
// buffer is empty, and peek walks the unread bytes at one store read per cycle,
// or answers without a read when nothing is unread.
// Reset is synchronous on rst and needs no clearing pass; the byte store
// holds no valid bits. The receiver cannot stall results, so rsp_valid is
// held for exactly one cycle per result.
module console_line_rx_buffer_top import clrb_pkg::*; #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  clrb_cmd_t         cmd,
  output logic              rsp_valid,
  output clrb_rsp_t         rsp
);

  localparam int PW = $clog2(BUFFER_DEPTH);

  logic        echo_disable;
  logic [12:0] max_line_length;
  logic        cfg_write;

  logic        q_full;
  logic        q_push;
  clrb_entry_t q_entry;
  clrb_entry_t q_head;
  logic        q_head_valid;
  logic        q_take;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Configuration: address bit 2 selects the register, writes are registered
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_disable    <= 1'b0;
      max_line_length <= MAX_LINE_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ECHO_DIS: echo_disable    <= pwdata[0];
        REG_MAX_LINE: max_line_length <= pwdata[12:0];
        default:      echo_disable    <= echo_disable;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ECHO_DIS: prdata = {31'b0, echo_disable};
      REG_MAX_LINE: prdata = {19'b0, max_line_length};
      default:      prdata = '0;
    endcase
  end

  // Front: accept and classify; drop unknown operations
  clrb_front u_front (
    .start           (start),
    .cmd             (cmd),
    .echo_disable    (echo_disable),
    .max_line_length (max_line_length),
    .q_full          (q_full),
    .busy            (busy),
    .push            (q_push),
    .entry           (q_entry)
  );

  // Queue: decouple acceptance from execution
  clrb_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .entry      (q_entry),
    .full       (q_full),
    .take       (q_take),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  // Back: edit, store, pop and search the ring buffer
  clrb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_head_valid),
    .head_take  (q_take),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .rsp        (rsp),
    .rsp_valid  (rsp_valid)
  );

  // Byte store of the ring buffer
  clrb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
